@@ hdl/knn_pkg.sv @@
package knn_pkg;

   localparam int MAX_SAMPLES  = 1024;
   localparam int MAX_FEATURES = 32;
   localparam int MAX_K        = 16;
   localparam int FEATURE_BITS = 16;

   localparam int SAMPLE_BITS  = $clog2(MAX_SAMPLES);
   localparam int TOTAL_BITS   = $clog2(MAX_SAMPLES + 1);
   localparam int FEAT_BITS    = $clog2(MAX_FEATURES);
   localparam int POS_BITS     = $clog2(MAX_FEATURES + 2);
   localparam int K_BITS       = $clog2(MAX_K);
   localparam int FILL_BITS    = $clog2(MAX_K + 1);
   localparam int STORE_BITS   = SAMPLE_BITS + FEAT_BITS;
   localparam int DIFF_BITS    = FEATURE_BITS + 1;
   localparam int SQ_BITS      = 2 * FEATURE_BITS;
   localparam int DIST_BITS    = SQ_BITS + FEAT_BITS + 1;
   localparam int LABEL_BITS   = 8;
   localparam int CFG_BITS     = 6;
   localparam int NC_BITS      = 5;
   localparam int FC_BITS      = 6;

   localparam logic [1:0] OP_TRAIN  = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic CSR_NEIGHBOUR_COUNT = 1'b0;
   localparam logic CSR_FEATURE_COUNT   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_OFFER,
      ST_VOTE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    start;
      logic [SAMPLE_BITS-1:0]  slot;
      logic [FEAT_BITS-1:0]    elem;
      logic                    first;
      logic                    last;
   } mac_ctl_type;

   typedef struct packed {
      logic                 valid;
      logic [DIST_BITS-1:0] distance;
   } mac_sts_type;

endpackage

@@ hdl/knn_if.sv @@
interface knn_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic signed [15:0] feature_value;
   logic [7:0]  sample_label;
   logic        last_feature;
   modport source (output valid, operation, feature_value, sample_label, last_feature,
                   input ready);
   modport sink (input valid, operation, feature_value, sample_label, last_feature,
                 output ready);
endinterface

interface knn_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  class_label;
   logic        store_empty;
   logic        length_mismatch;
   modport source (output valid, class_label, store_empty, length_mismatch, input ready);
   modport sink (input valid, class_label, store_empty, length_mismatch, output ready);
endinterface

@@ hdl/knn_mac.sv @@
module knn_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  knn_pkg::mac_ctl_type                   ctl,
   input  logic signed [knn_pkg::FEATURE_BITS-1:0] query_value,
   input  logic                                   wr_en,
   input  logic [knn_pkg::STORE_BITS-1:0]         wr_addr,
   input  logic signed [knn_pkg::FEATURE_BITS-1:0] wr_data,
   output knn_pkg::mac_sts_type                   sts
);

   logic signed [knn_pkg::FEATURE_BITS-1:0]
      store_mem [knn_pkg::MAX_SAMPLES*knn_pkg::MAX_FEATURES];
   logic signed [knn_pkg::FEATURE_BITS-1:0] rd_ff;
   logic signed [knn_pkg::FEATURE_BITS-1:0] q_ff;
   logic        s1_ff, s1_first_ff, s1_last_ff;
   logic        s2_ff, s2_first_ff, s2_last_ff;
   logic [knn_pkg::DIFF_BITS-1:0] abs_ff;
   logic signed [knn_pkg::DIFF_BITS-1:0] diff;
   logic [knn_pkg::SQ_BITS-1:0] sq_ff;
   logic        s3_ff, s3_first_ff, s3_last_ff;
   logic [knn_pkg::DIST_BITS-1:0] acc_ff, acc_in;
   logic        valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      rd_ff <= store_mem[{ctl.slot, ctl.elem}];
      q_ff  <= query_value;
   end

   assign diff = knn_pkg::DIFF_BITS'(q_ff) - knn_pkg::DIFF_BITS'(rd_ff);

   always_ff @(posedge clock) begin
      abs_ff <= diff[knn_pkg::DIFF_BITS-1] ? knn_pkg::DIFF_BITS'(-diff) : diff;
      sq_ff  <= knn_pkg::SQ_BITS'(abs_ff) * knn_pkg::SQ_BITS'(abs_ff);
      acc_ff <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (s3_ff) acc_in = (s3_first_ff ? '0 : acc_ff) + knn_pkg::DIST_BITS'(sq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0; s2_ff <= 1'b0; s3_ff <= 1'b0; valid_ff <= 1'b0;
      end else begin
         s1_ff <= ctl.start; s2_ff <= s1_ff; s3_ff <= s2_ff;
         valid_ff <= s3_ff && s3_last_ff;
      end
      s1_first_ff <= ctl.first; s1_last_ff <= ctl.last;
      s2_first_ff <= s1_first_ff; s2_last_ff <= s1_last_ff;
      s3_first_ff <= s2_first_ff; s3_last_ff <= s2_last_ff;
   end

   assign sts.valid    = valid_ff;
   assign sts.distance = acc_ff;

endmodule

@@ hdl/knn_majority_classifier_unit.sv @@
// k-nearest-neighbour classifier. Each request carries one feature element;
// training vectors go to an on-chip sample store, and the last element of a
// query starts a scan: one pipelined subtract-square-accumulate lane reads
// the sample store one element per cycle, but starts a new sample only
// after the previous sample's distance has been offered to the sorted list
// of the K nearest, which shifts one step per cycle; the vote then counts
// one neighbour pair per cycle over the neighbours in the list (fewer than
// K when fewer samples are stored), and the DONE state posts the result.
// req_ready stays low from the last query element until the result is
// taken, and while any result waits. Training and clear requests do not
// start a scan. Squared distance sums of up to 32 features never saturate at these widths.
module knn_majority_classifier_unit (
   input  logic           clock,
   input  logic           reset,
   knn_req_if.sink        req,
   knn_rsp_if.source      rsp,
   input  logic           csr_we,
   input  logic           csr_index,
   input  logic [knn_pkg::CFG_BITS-1:0] csr_data
);

   localparam int SB = knn_pkg::SAMPLE_BITS;
   localparam int FB = knn_pkg::FEAT_BITS;
   localparam int DB = knn_pkg::DIST_BITS;
   localparam int LB = knn_pkg::LABEL_BITS;
   localparam int KB = knn_pkg::K_BITS;
   localparam int NB = knn_pkg::FILL_BITS;

   knn_pkg::state_type state_ff, state_in;

   logic [knn_pkg::NC_BITS-1:0] nc_ff;
   logic [knn_pkg::FC_BITS-1:0] fc_ff;
   logic [knn_pkg::TOTAL_BITS-1:0] total_ff, total_in;
   logic [knn_pkg::POS_BITS-1:0] pos_ff, pos_in;
   logic signed [knn_pkg::FEATURE_BITS-1:0] qbuf_ff [knn_pkg::MAX_FEATURES];
   logic [LB-1:0] label_mem [knn_pkg::MAX_SAMPLES];
   logic [LB-1:0] lbl_rd_ff;
   logic [LB-1:0] lbl_rd_hold_ff;

   logic [DB-1:0] nd_ff [knn_pkg::MAX_K];
   logic [LB-1:0] nl_ff [knn_pkg::MAX_K];
   logic [NB-1:0] fill_ff, fill_in;
   logic [NB-1:0] k_ff;

   logic [SB:0]   iss_slot_ff, iss_slot_in;
   logic [FB-1:0] iss_elem_ff, iss_elem_in;
   logic [SB:0]   done_cnt_ff, done_cnt_in;
   logic [DB-1:0] od_ff;
   logic [LB-1:0] ol_ff;
   logic [NB-1:0] opos_ff, opos_in;
   logic          offering_ff;
   logic          iss_active_ff;
   logic          issuing;
   logic          insert;
   logic          shift;

   logic [KB-1:0] vi_ff, vj_ff;
   logic [NB-1:0] vc_ff, best_cnt_ff;
   logic [LB-1:0] best_ff;

   logic          rsp_valid_ff;
   logic [LB-1:0] rsp_label_ff;
   logic          rsp_empty_ff, rsp_mis_ff;

   knn_pkg::mac_ctl_type mctl;
   knn_pkg::mac_sts_type msts;

   logic take, is_last, mismatch, wr_store, lbl_we;
   logic [knn_pkg::POS_BITS-1:0] pos_inc;

   assign req.ready = (state_ff == knn_pkg::ST_IDLE) && !rsp_valid_ff;
   assign take      = req.valid && req.ready;
   assign is_last   = req.last_feature;
   assign pos_inc   = (pos_ff <= knn_pkg::POS_BITS'(knn_pkg::MAX_FEATURES)) ?
                      pos_ff + 1'b1 : pos_ff;

   assign mismatch = (fc_ff == '0) || (fc_ff > knn_pkg::FC_BITS'(knn_pkg::MAX_FEATURES)) ||
                     (knn_pkg::POS_BITS'(fc_ff) != pos_inc);

   assign wr_store = take && req.operation == knn_pkg::OP_TRAIN &&
                     pos_ff < knn_pkg::POS_BITS'(knn_pkg::MAX_FEATURES) &&
                     total_ff < knn_pkg::TOTAL_BITS'(knn_pkg::MAX_SAMPLES);
   assign lbl_we = take && req.operation == knn_pkg::OP_TRAIN && is_last && !mismatch &&
                   total_ff < knn_pkg::TOTAL_BITS'(knn_pkg::MAX_SAMPLES);

   always_ff @(posedge clock) begin
      if (reset) begin
         nc_ff <= knn_pkg::NC_BITS'(1);
         fc_ff <= knn_pkg::FC_BITS'(32);
      end else if (csr_we) begin
         unique case (csr_index)
            knn_pkg::CSR_NEIGHBOUR_COUNT: nc_ff <= csr_data[knn_pkg::NC_BITS-1:0];
            knn_pkg::CSR_FEATURE_COUNT:   fc_ff <= csr_data[knn_pkg::FC_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (take && req.operation == knn_pkg::OP_QUERY &&
          pos_ff < knn_pkg::POS_BITS'(knn_pkg::MAX_FEATURES))
         qbuf_ff[pos_ff[FB-1:0]] <= req.feature_value;
      if (lbl_we) label_mem[total_ff[SB-1:0]] <= req.sample_label;
      lbl_rd_ff <= label_mem[iss_slot_ff[SB-1:0]];
   end

   always_comb begin
      pos_in   = pos_ff;
      total_in = total_ff;
      if (take) begin
         if (req.operation == knn_pkg::OP_CLEAR) begin
            pos_in = '0; total_in = '0;
         end else if (req.operation != knn_pkg::OP_UNUSED) begin
            pos_in = is_last ? '0 : pos_inc;
            if (lbl_we) total_in = total_ff + 1'b1;
         end
      end
   end

   knn_mac u_mac (
      .clock(clock), .reset(reset), .ctl(mctl),
      .query_value(qbuf_ff[iss_elem_ff]),
      .wr_en(wr_store),
      .wr_addr({total_ff[SB-1:0], pos_ff[FB-1:0]}),
      .wr_data(req.feature_value),
      .sts(msts)
   );

   assign issuing = state_ff == knn_pkg::ST_DIST && !offering_ff && !msts.valid &&
                    iss_slot_ff < (SB+1)'(total_ff) && done_cnt_ff == iss_slot_ff;

   always_comb begin
      mctl.start = iss_active_ff;
      mctl.slot  = iss_slot_ff[SB-1:0];
      mctl.elem  = iss_elem_ff;
      mctl.first = iss_elem_ff == '0;
      mctl.last  = iss_elem_ff == FB'(fc_ff - 1'b1);
   end

   always_comb begin
      state_in    = state_ff;
      iss_slot_in = iss_slot_ff;
      iss_elem_in = iss_elem_ff;
      done_cnt_in = done_cnt_ff;
      fill_in     = fill_ff;
      opos_in     = opos_ff;
      unique case (state_ff)
         knn_pkg::ST_IDLE: begin
            if (take && req.operation == knn_pkg::OP_QUERY && is_last &&
                total_ff != '0 && !mismatch) begin
               state_in = knn_pkg::ST_DIST;
               iss_slot_in = '0; iss_elem_in = '0; done_cnt_in = '0; fill_in = '0;
            end
         end
         knn_pkg::ST_DIST: begin
            if (iss_active_ff) begin
               if (mctl.last) begin
                  iss_elem_in = '0; iss_slot_in = iss_slot_ff + 1'b1;
               end else iss_elem_in = iss_elem_ff + 1'b1;
            end
            if (msts.valid) begin
               done_cnt_in = done_cnt_ff + 1'b1;
               state_in = knn_pkg::ST_OFFER;
               opos_in = (fill_ff >= k_ff) ? k_ff - 1'b1 : fill_ff;
            end
         end
         knn_pkg::ST_OFFER: begin
            if (fill_ff >= k_ff && od_ff >= nd_ff[KB'(k_ff - 1'b1)]) begin
               state_in = (done_cnt_ff == (SB+1)'(total_ff)) ? knn_pkg::ST_VOTE :
                          knn_pkg::ST_DIST;
            end else if (opos_ff != '0 && od_ff < nd_ff[KB'(opos_ff - 1'b1)]) begin
               opos_in = opos_ff - 1'b1;
            end else begin
               if (fill_ff < k_ff) fill_in = fill_ff + 1'b1;
               state_in = (done_cnt_ff == (SB+1)'(total_ff)) ? knn_pkg::ST_VOTE :
                          knn_pkg::ST_DIST;
            end
         end
         knn_pkg::ST_VOTE: begin
            if (vi_ff == KB'(fill_ff - 1'b1) && vj_ff == KB'(fill_ff - 1'b1))
               state_in = knn_pkg::ST_DONE;
         end
         knn_pkg::ST_DONE: state_in = knn_pkg::ST_IDLE;
         default: state_in = knn_pkg::ST_IDLE;
      endcase
   end

   assign insert = state_ff == knn_pkg::ST_OFFER &&
                   !(fill_ff >= k_ff && od_ff >= nd_ff[KB'(k_ff - 1'b1)]) &&
                   !(opos_ff != '0 && od_ff < nd_ff[KB'(opos_ff - 1'b1)]);
   assign shift = state_ff == knn_pkg::ST_OFFER &&
                  !(fill_ff >= k_ff && od_ff >= nd_ff[KB'(k_ff - 1'b1)]) &&
                  (opos_ff != '0 && od_ff < nd_ff[KB'(opos_ff - 1'b1)]);

   always_ff @(posedge clock) begin
      if (msts.valid) begin
         od_ff <= msts.distance; ol_ff <= lbl_rd_hold_ff;
      end
      if (shift) begin
         nd_ff[KB'(opos_ff)] <= nd_ff[KB'(opos_ff - 1'b1)];
         nl_ff[KB'(opos_ff)] <= nl_ff[KB'(opos_ff - 1'b1)];
      end
      if (insert) begin
         nd_ff[KB'(opos_ff)] <= od_ff;
         nl_ff[KB'(opos_ff)] <= ol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (iss_active_ff && mctl.first) lbl_rd_hold_ff <= lbl_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == knn_pkg::ST_IDLE) begin
         vi_ff <= '0; vj_ff <= '0; vc_ff <= '0; best_cnt_ff <= '0; best_ff <= '0;
      end else if (state_ff == knn_pkg::ST_VOTE) begin
         logic [NB-1:0] c;
         c = vc_ff + NB'(nl_ff[vj_ff] == nl_ff[vi_ff]);
         if (vj_ff == KB'(fill_ff - 1'b1)) begin
            if (c > best_cnt_ff || (c == best_cnt_ff && nl_ff[vi_ff] < best_ff)) begin
               best_cnt_ff <= c; best_ff <= nl_ff[vi_ff];
            end
            vc_ff <= '0; vj_ff <= '0; vi_ff <= vi_ff + 1'b1;
         end else begin
            vc_ff <= c; vj_ff <= vj_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= knn_pkg::ST_IDLE;
         total_ff <= '0; pos_ff <= '0; fill_ff <= '0;
         iss_active_ff <= 1'b0; offering_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in; pos_ff <= pos_in; fill_ff <= fill_in;
         if (issuing && !iss_active_ff) iss_active_ff <= 1'b1;
         else if (iss_active_ff && mctl.last) iss_active_ff <= 1'b0;
         offering_ff <= state_in == knn_pkg::ST_OFFER;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         else if ((take && req.operation == knn_pkg::OP_QUERY && is_last &&
                   (total_ff == '0 || mismatch)) || state_ff == knn_pkg::ST_DONE)
            rsp_valid_ff <= 1'b1;
      end
      iss_slot_ff <= iss_slot_in; iss_elem_ff <= iss_elem_in;
      done_cnt_ff <= done_cnt_in; opos_ff <= opos_in;
      if (take && is_last && req.operation == knn_pkg::OP_QUERY) begin
         rsp_empty_ff <= total_ff == '0;
         rsp_mis_ff   <= mismatch;
         rsp_label_ff <= '0;
         k_ff <= (nc_ff == '0) ? NB'(1) :
                 (nc_ff > knn_pkg::NC_BITS'(knn_pkg::MAX_K)) ? NB'(knn_pkg::MAX_K) :
                 NB'(nc_ff);
      end
      if (state_ff == knn_pkg::ST_DONE) rsp_label_ff <= best_ff;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.class_label     = rsp_label_ff;
   assign rsp.store_empty     = rsp_empty_ff;
   assign rsp.length_mismatch = rsp_mis_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != knn_pkg::ST_IDLE |-> !req.ready)
      else $error("request accepted during scan");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NB'(knn_pkg::MAX_K))
      else $error("neighbour list overfilled");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.class_label))
      else $error("response dropped while stalled");

endmodule
